// ===== hw/rtl/indexed_min_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// indexed min priority queue assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef INDEXED_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define INDEXED_MIN_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication
`define IMQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("imq assertion failed");

// next-cycle implication
`define IMQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("imq assertion failed");

`endif

// ===== hw/rtl/imq_pkg.sv =====
// ----------------------------------------------------------------------------
// imq_pkg
// types and constants of the indexed min priority queue
// ----------------------------------------------------------------------------
package imq_pkg;

  localparam int unsigned KeyBits     = 32;
  localparam int unsigned PayloadBits = 32;
  localparam int unsigned IdBits      = 8;
  localparam int unsigned LimitBits   = 9;
  localparam logic [LimitBits-1:0] LimitReset = 9'd256;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_SET_KEY = 2'd1,
    CMD_DEL_MIN = 2'd2,
    CMD_REMOVE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e                     command;
    logic [IdBits-1:0]        entry_id;
    logic signed [KeyBits-1:0] key_value;
    logic [PayloadBits-1:0]   payload;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic [IdBits-1:0]        out_id;
    logic signed [KeyBits-1:0] out_key;
    logic [PayloadBits-1:0]   out_payload;
  } out_t;

  typedef struct packed {
    logic signed [KeyBits-1:0] key;
    logic [IdBits-1:0]        handle;
    logic [PayloadBits-1:0]   payload;
  } slot_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SK_LOAD, S_RM_LOAD, S_TAKE, S_LAST_LOAD,
    S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_L, S_DN_R, S_DN_CMP, S_PLACE, S_FINISH
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_FAIL, OP_INSERT, OP_SK_READ, OP_DM_TAKE, OP_RM_READ,
    OP_SK_LOAD, OP_RM_LOAD, OP_TAKE, OP_LAST_LOAD, OP_UP_READ, OP_UP_MOVE,
    OP_DN_READ, OP_DN_LEFT, OP_DN_RIGHT, OP_DN_MOVE, OP_PLACE, OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fail;
    cmd_e cmd;
    logic old_lt;
    logic old_gt;
    logic pos_last;
    logic pos_zero;
    logic has_left;
    logic has_right;
    logic e_lt_rd;
    logic e_gt_child;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hw/rtl/imq_ram.sv =====
// ----------------------------------------------------------------------------
// imq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module imq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/imq_ctrl.sv =====
// ----------------------------------------------------------------------------
// imq_ctrl
// command sequencer: checks, take-out and sift steps
// ----------------------------------------------------------------------------
module imq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  imq_pkg::dp_sts_t   sts_i,
  output imq_pkg::ctrl_cmd_t cmd_o,
  output logic               busy_o
);
  import imq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.fail) begin
          cmd_o.op = OP_FAIL;
          state_d  = S_FINISH;
        end else begin
          unique case (sts_i.cmd)
            CMD_INSERT: begin
              cmd_o.op = OP_INSERT;
              state_d  = S_UP_RD;
            end
            CMD_SET_KEY: begin
              cmd_o.op = OP_SK_READ;
              state_d  = S_SK_LOAD;
            end
            CMD_DEL_MIN: begin
              cmd_o.op = OP_DM_TAKE;
              state_d  = S_TAKE;
            end
            default: begin
              cmd_o.op = OP_RM_READ;
              state_d  = S_RM_LOAD;
            end
          endcase
        end
      end
      S_SK_LOAD, S_LAST_LOAD: begin
        cmd_o.op = (state_q == S_SK_LOAD) ? OP_SK_LOAD : OP_LAST_LOAD;
        if (sts_i.old_lt) begin
          state_d = S_DN_RD;
        end else if (sts_i.old_gt) begin
          state_d = S_UP_RD;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_RM_LOAD: begin
        cmd_o.op = OP_RM_LOAD;
        state_d  = S_TAKE;
      end
      S_TAKE: begin
        cmd_o.op = OP_TAKE;
        state_d  = sts_i.pos_last ? S_FINISH : S_LAST_LOAD;
      end
      S_UP_RD: begin
        cmd_o.op = OP_UP_READ;
        state_d  = sts_i.pos_zero ? S_PLACE : S_UP_CMP;
      end
      S_UP_CMP: begin
        if (sts_i.e_lt_rd) begin
          cmd_o.op = OP_UP_MOVE;
          state_d  = S_UP_RD;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_DN_RD: begin
        cmd_o.op = OP_DN_READ;
        state_d  = sts_i.has_left ? S_DN_L : S_PLACE;
      end
      S_DN_L: begin
        cmd_o.op = OP_DN_LEFT;
        state_d  = sts_i.has_right ? S_DN_R : S_DN_CMP;
      end
      S_DN_R: begin
        cmd_o.op = OP_DN_RIGHT;
        state_d  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (sts_i.e_gt_child) begin
          cmd_o.op = OP_DN_MOVE;
          state_d  = S_DN_RD;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.op = OP_PLACE;
        state_d  = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.op = OP_FINISH;
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hw/rtl/imq_dp.sv =====
// ----------------------------------------------------------------------------
// imq_dp
// heap datapath: slot and position rams, presence bits, output register
// ----------------------------------------------------------------------------
module imq_dp #(
  parameter int unsigned CAPACITY     = 256,
  parameter int unsigned HANDLE_COUNT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  imq_pkg::ctrl_cmd_t  cmd_i,
  output imq_pkg::dp_sts_t    sts_o,
  input  imq_pkg::in_t        in_word_i,
  input  logic                cfg_we_i,
  input  logic [8:0]          cfg_wdata_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output imq_pkg::out_t       out_word_o
);
  import imq_pkg::*;

  localparam int unsigned Handles = (HANDLE_COUNT < 256) ? HANDLE_COUNT : 256;
  localparam int unsigned HidW    = $clog2(Handles);
  localparam int unsigned PosW    = $clog2(CAPACITY);
  localparam int unsigned CntW    = $clog2(CAPACITY + 1);
  localparam int unsigned LimW    = (CntW > LimitBits) ? CntW : LimitBits;
  localparam int unsigned ChW     = PosW + 2;

  cmd_e                    cmd_q;
  logic [IdBits-1:0]       id_q;
  logic signed [KeyBits-1:0] key_q;
  logic [PayloadBits-1:0]  pay_q;
  logic [LimitBits-1:0]    limit_q;
  logic [CntW-1:0]         count_q;
  logic [Handles-1:0]      present_q;
  logic [PosW-1:0]         pos_q;
  logic [PosW-1:0]         cidx_q;
  slot_t                   ent_q;
  slot_t                   child_q;
  slot_t                   taken_q;
  status_e                 st_q;
  logic                    take_q;
  logic                    out_valid_q;
  out_t                    out_q;

  slot_t                   slot_rd;
  slot_t                   slot_wdata;
  logic                    slot_we;
  logic [PosW-1:0]         slot_raddr;
  logic [PosW-1:0]         slot_waddr;
  logic [PosW-1:0]         posr;
  logic                    pos_we;
  logic [HidW-1:0]         pos_waddr;

  logic [LimW-1:0]         eff_limit;
  logic                    h_ok;
  logic [HidW-1:0]         hidx;
  logic [HidW-1:0]         tidx;
  logic [PosW-1:0]         parent;
  logic [ChW-1:0]          c_w;
  logic [ChW-1:0]          c1_w;
  logic [ChW-1:0]          cnt_w;
  logic [CntW-1:0]         last_w;
  logic signed [KeyBits-1:0] old_key;
  logic signed [KeyBits-1:0] new_key;
  status_e                 fail_code;
  logic                    out_free;

  imq_ram #(.WIDTH($bits(slot_t)), .DEPTH(CAPACITY)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rd)
  );

  imq_ram #(.WIDTH(PosW), .DEPTH(Handles)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_q),
    .raddr_i (in_word_i.entry_id[HidW-1:0]),
    .rdata_o (posr)
  );

  assign eff_limit = (LimW'(limit_q) > LimW'(CAPACITY)) ? LimW'(CAPACITY) : LimW'(limit_q);
  assign h_ok      = ({1'b0, id_q} < 9'(Handles));
  assign hidx      = id_q[HidW-1:0];
  assign tidx      = taken_q.handle[HidW-1:0];
  assign parent    = PosW'((pos_q - 1'b1) >> 1);
  assign c_w       = {1'b0, pos_q, 1'b1};
  assign c1_w      = c_w + 1'b1;
  assign cnt_w     = ChW'(count_q);
  assign last_w    = count_q - 1'b1;
  assign out_free  = !out_valid_q || !out_stall_i;

  // early checks: insert and delete-min have their own arms, set-key and remove share one
  always_comb begin
    fail_code = ST_OK;
    case (cmd_q)
      CMD_INSERT: begin
        if (LimW'(count_q) >= eff_limit) begin
          fail_code = ST_FULL;
        end else if (!h_ok) begin
          fail_code = ST_NOT_FOUND;
        end else if (present_q[hidx]) begin
          fail_code = ST_PRESENT;
        end
      end
      CMD_DEL_MIN: begin
        if (count_q == '0) begin
          fail_code = ST_EMPTY;
        end
      end
      default: begin
        if (!h_ok || !present_q[hidx] || (CntW'(posr) >= count_q)) begin
          fail_code = ST_NOT_FOUND;
        end
      end
    endcase
  end

  assign old_key = (cmd_i.op == OP_LAST_LOAD) ? taken_q.key : slot_rd.key;
  assign new_key = (cmd_i.op == OP_LAST_LOAD) ? slot_rd.key : key_q;

  assign sts_o.fail       = (fail_code != ST_OK);
  assign sts_o.cmd        = cmd_q;
  assign sts_o.old_lt     = (old_key < new_key);
  assign sts_o.old_gt     = (old_key > new_key);
  assign sts_o.pos_last   = (CntW'(pos_q) == last_w);
  assign sts_o.pos_zero   = (pos_q == '0);
  assign sts_o.has_left   = (c_w < cnt_w);
  assign sts_o.has_right  = (c1_w < cnt_w);
  assign sts_o.e_lt_rd    = (ent_q.key < slot_rd.key);
  assign sts_o.e_gt_child = (ent_q.key > child_q.key);
  assign sts_o.out_free   = out_free;

  // ram addressing
  always_comb begin
    slot_raddr = '0;
    slot_we    = 1'b0;
    slot_waddr = pos_q;
    slot_wdata = ent_q;
    pos_we     = 1'b0;
    pos_waddr  = ent_q.handle[HidW-1:0];
    case (cmd_i.op)
      OP_SK_READ, OP_RM_READ: slot_raddr = posr;
      OP_TAKE:                slot_raddr = last_w[PosW-1:0];
      OP_UP_READ:             slot_raddr = parent;
      OP_DN_READ:             slot_raddr = c_w[PosW-1:0];
      OP_DN_LEFT:             slot_raddr = c1_w[PosW-1:0];
      OP_UP_MOVE: begin
        slot_we    = 1'b1;
        slot_wdata = slot_rd;
        pos_we     = 1'b1;
        pos_waddr  = slot_rd.handle[HidW-1:0];
      end
      OP_DN_MOVE: begin
        slot_we    = 1'b1;
        slot_wdata = child_q;
        pos_we     = 1'b1;
        pos_waddr  = child_q.handle[HidW-1:0];
      end
      OP_PLACE: begin
        slot_we = 1'b1;
        pos_we  = 1'b1;
      end
      default: ;
    endcase
  end

  // command fields and working entries
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        cmd_q <= in_word_i.command;
        id_q  <= in_word_i.entry_id;
        key_q <= in_word_i.key_value;
        pay_q <= in_word_i.payload;
      end
      OP_INSERT: begin
        ent_q <= '{key: key_q, handle: id_q, payload: pay_q};
        pos_q <= count_q[PosW-1:0];
      end
      OP_SK_READ, OP_RM_READ: pos_q <= posr;
      OP_DM_TAKE: begin
        taken_q <= slot_rd;
        pos_q   <= '0;
      end
      OP_RM_LOAD:   taken_q <= slot_rd;
      OP_SK_LOAD:   ent_q   <= '{key: key_q, handle: slot_rd.handle, payload: slot_rd.payload};
      OP_LAST_LOAD: ent_q   <= slot_rd;
      OP_UP_MOVE:   pos_q   <= parent;
      OP_DN_LEFT: begin
        child_q <= slot_rd;
        cidx_q  <= c_w[PosW-1:0];
      end
      OP_DN_RIGHT: begin
        if (child_q.key > slot_rd.key) begin
          child_q <= slot_rd;
          cidx_q  <= c1_w[PosW-1:0];
        end
      end
      OP_DN_MOVE:   pos_q <= cidx_q;
      default: ;
    endcase
  end

  // control state: count, presence, status, take flag, limit, output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= LimitReset;
      count_q     <= '0;
      present_q   <= '0;
      st_q        <= ST_OK;
      take_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      // a new result replaces a taken one in the same cycle
      if (cmd_i.op == OP_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_ACCEPT: begin
          st_q   <= ST_OK;
          take_q <= 1'b0;
        end
        OP_FAIL: st_q <= fail_code;
        OP_INSERT: begin
          present_q[hidx] <= 1'b1;
          count_q         <= count_q + 1'b1;
        end
        OP_TAKE: begin
          present_q[tidx] <= 1'b0;
          count_q         <= last_w;
          take_q          <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FINISH && out_free) begin
      out_q.status      <= st_q;
      out_q.out_id      <= take_q ? taken_q.handle  : '0;
      out_q.out_key     <= take_q ? taken_q.key     : '0;
      out_q.out_payload <= take_q ? taken_q.payload : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ===== hw/rtl/indexed_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_min_priority_queue
// binary min-heap of (handle, key, payload) with a per-handle position table
// ----------------------------------------------------------------------------
//  channel  direction  word       handshake
//  in       input      in_t       in_valid_i / in_stall_o
//  out      output     out_t      out_valid_o / out_stall_i
//  cfg      input      9-bit      cfg_we_i (capacity limit, no read-back)
//
//  one word at a time; a check failure goes straight to the finish step, and
//  a sift moves one level up or down per step, each step reading through the
//  single read port of the slot ram (up to 8 levels at 256 entries)
//  the result sits in an output register, so a new word is taken while it waits
//  reset clears the count and the presence bits at once; no clearing pass
//  a stalled output holds the block in its finish step until the slot frees
// ----------------------------------------------------------------------------
module indexed_min_priority_queue #(
  parameter int unsigned CAPACITY     = 256,
  parameter int unsigned HANDLE_COUNT = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  imq_pkg::in_t  in_word_i,
  input  logic          cfg_we_i,
  input  logic [8:0]    cfg_wdata_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output imq_pkg::out_t out_word_o
);
  import imq_pkg::*;

  // command from the sequencer, flags back from the datapath
  ctrl_cmd_t ctrl_cmd;
  dp_sts_t   dp_sts;
  logic      busy;

  // sequencer: checks, take-out, then sift up or down level by level
  imq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (dp_sts),
    .cmd_o      (ctrl_cmd),
    .busy_o     (busy)
  );

  // datapath: heap slots and position table in ram, presence bits in flops
  imq_dp #(
    .CAPACITY     (CAPACITY),
    .HANDLE_COUNT (HANDLE_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // a word is taken only when the sequencer is idle
  assign in_stall_o = busy;

endmodule

// ===== hw/rtl/imq_checker.sv =====
// ----------------------------------------------------------------------------
// imq_checker
// port-level checks of the indexed min priority queue
// ----------------------------------------------------------------------------
`include "indexed_min_priority_queue_assert.svh"

module imq_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input imq_pkg::in_t  in_word_i,
  input logic          cfg_we_i,
  input logic [8:0]    cfg_wdata_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input imq_pkg::out_t out_word_o
);
  import imq_pkg::*;

  // a stalled result stays and holds its word
  `IMQ_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `IMQ_ASSERT_NXT(a_out_stable, out_valid_o && out_stall_i, $stable(out_word_o))
  // one word at a time: after an accept the input is stalled
  `IMQ_ASSERT_NXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // nothing taken out on a failed command
  `IMQ_ASSERT_IMP(a_fail_zero, out_valid_o && (out_word_o.status != ST_OK),
                  (out_word_o.out_id == '0) && (out_word_o.out_key == '0) &&
                  (out_word_o.out_payload == '0))

endmodule

bind indexed_min_priority_queue imq_checker u_imq_checker (.*);
